### rtl/core/tvod_pkg.sv
// Shared types and constants for the tagged varint operand decoder.
package tvod_pkg;

  // Header byte fields and length prefix patterns (bits 5..0 of an index header).
  localparam logic [5:0] LEN1_MASK = 6'h20;
  localparam logic [5:0] LEN2_MASK = 6'h38;
  localparam logic [5:0] LEN2_CODE = 6'h30;
  localparam logic [5:0] LEN3_MASK = 6'h3C;
  localparam logic [5:0] LEN3_CODE = 6'h38;
  localparam logic [5:0] LEN4_MASK = 6'h3E;
  localparam logic [5:0] LEN4_CODE = 6'h3C;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PREFIX = 2'd1,
    ST_TRUNCATED  = 2'd2
  } status_e;

  // Field decode state carried between items.
  typedef struct packed {
    logic        in_field;
    logic        is_count;
    logic [1:0]  tag;
    logic [1:0]  remaining;
    logic [1:0]  position;
    logic [31:0] acc;
  } dec_state_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  tag;
    logic [31:0] value;
    logic        was_count;
    status_e     status;
  } dec_result_t;

endpackage

### rtl/core/tvod_step.sv
// Combinational decode of one code byte against the current field state.
module tvod_step (
  input  tvod_pkg::dec_state_t  cur_i,
  input  logic                  kind_i,
  input  logic [7:0]            code_byte_i,
  input  logic                  end_of_code_i,
  output tvod_pkg::dec_state_t  nxt_o,
  output tvod_pkg::dec_result_t res_o,
  output logic                  emit_o
);
  import tvod_pkg::*;

  logic [5:0] low6;
  logic       hdr_ok;
  status_e    status;
  logic [31:0] value;

  assign low6 = code_byte_i[5:0];

  // Next state and result for this byte.
  always_comb begin
    nxt_o  = cur_i;
    emit_o = 1'b0;
    hdr_ok = 1'b0;
    status = ST_OK;
    value  = '0;
    if (!cur_i.in_field) begin
      if (kind_i) begin
        // Count header: first byte is the least significant one.
        nxt_o.is_count  = 1'b1;
        nxt_o.tag       = 2'd0;
        nxt_o.acc       = {24'd0, code_byte_i};
        nxt_o.position  = 2'd1;
        nxt_o.remaining = 2'd3;
        hdr_ok          = 1'b1;
      end else begin
        // Index header: tag in bits 7..6, length prefix below.
        nxt_o.is_count = 1'b0;
        nxt_o.tag      = code_byte_i[7:6];
        nxt_o.position = 2'd0;
        if ((low6 & LEN1_MASK) == 6'd0) begin
          emit_o = 1'b1;
          value  = {27'd0, low6[4:0]};
        end else if ((low6 & LEN2_MASK) == LEN2_CODE) begin
          nxt_o.acc       = {29'd0, low6[2:0]};
          nxt_o.remaining = 2'd1;
          hdr_ok          = 1'b1;
        end else if ((low6 & LEN3_MASK) == LEN3_CODE) begin
          nxt_o.acc       = {30'd0, low6[1:0]};
          nxt_o.remaining = 2'd2;
          hdr_ok          = 1'b1;
        end else if ((low6 & LEN4_MASK) == LEN4_CODE) begin
          nxt_o.acc       = {31'd0, low6[0]};
          nxt_o.remaining = 2'd3;
          hdr_ok          = 1'b1;
        end else begin
          emit_o = 1'b1;
          status = ST_BAD_PREFIX;
        end
      end
      // A multi-byte field that starts on the last code byte is cut off.
      if (hdr_ok) begin
        nxt_o.in_field = 1'b1;
        if (end_of_code_i) begin
          emit_o = 1'b1;
          status = ST_TRUNCATED;
        end
      end
    end else begin
      // Continuation byte: counts fill bytes upward, indexes shift in six bits.
      if (cur_i.is_count) begin
        nxt_o.acc      = cur_i.acc | ({24'd0, code_byte_i} << {cur_i.position, 3'b000});
        nxt_o.position = cur_i.position + 2'd1;
      end else begin
        nxt_o.acc = {cur_i.acc[25:0], low6};
      end
      nxt_o.remaining = cur_i.remaining - 2'd1;
      if (nxt_o.remaining == 2'd0) begin
        emit_o = 1'b1;
        value  = nxt_o.acc;
      end else if (end_of_code_i) begin
        emit_o = 1'b1;
        status = ST_TRUNCATED;
      end
    end

    res_o.tag       = nxt_o.tag;
    res_o.was_count = nxt_o.is_count;
    res_o.value     = value;
    res_o.status    = status;

    // Any result closes the field.
    if (emit_o) begin
      nxt_o.in_field  = 1'b0;
      nxt_o.remaining = 2'd0;
      nxt_o.position  = 2'd0;
      nxt_o.acc       = '0;
    end
  end

endmodule

### rtl/core/tvod_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
module tvod_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  tvod_pkg::dec_result_t res_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            operand_tag_o,
  output logic [31:0]           decoded_value_o,
  output logic                  was_count_o,
  output logic [1:0]            status_o
);
  import tvod_pkg::*;

  logic        valid_q;
  dec_result_t res_q;

  // The slot can take a new result when empty or when its item leaves now.
  assign free_o = !valid_q || !out_stall_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign operand_tag_o   = res_q.tag;
  assign decoded_value_o = res_q.value;
  assign was_count_o     = res_q.was_count;
  assign status_o        = res_q.status;

endmodule

### rtl/core/tagged_varint_operand_decoder_unit.sv
// Top level of the tagged varint operand decoder: input register, field state, result register.
// Decodes a bytecode stream one byte per item. With kind low on the first byte of a field, the
// byte is an index header (tag in bits 7..6, length prefix in bits 5..0) followed by up to three
// continuation bytes of six bits each; with kind high the field is a four-byte little-endian
// count. One result item comes out when a field completes, when a header has an invalid prefix,
// or when end_of_code marks a byte before the field's end. Each byte sits in the input register,
// one pass of decode logic updates the field state, and any result is then written into the
// output register, where the consumer takes it. A new byte is accepted every cycle while the
// consumer keeps up; stall on the output propagates back only when a result must be written
// into a full output register.
module tagged_varint_operand_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  code_byte_i,
  input  logic        end_of_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  operand_tag_o,
  output logic [31:0] decoded_value_o,
  output logic        was_count_o,
  output logic [1:0]  status_o
);
  import tvod_pkg::*;

  logic        in_valid_q;
  logic        kind_q;
  logic [7:0]  byte_q;
  logic        last_q;
  dec_state_t  state_q;
  dec_state_t  state_d;
  dec_result_t res;
  logic        emit;
  logic        out_free;
  logic        go;

  // The held byte is processed unless it produces a result the output cannot take.
  assign go         = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !go;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q <= kind_i;
      byte_q <= code_byte_i;
      last_q <= end_of_code_i;
    end
  end

  // Field state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (go) begin
      state_q <= state_d;
    end
  end

  tvod_step u_step (
    .cur_i         (state_q),
    .kind_i        (kind_q),
    .code_byte_i   (byte_q),
    .end_of_code_i (last_q),
    .nxt_o         (state_d),
    .res_o         (res),
    .emit_o        (emit)
  );

  tvod_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (go && emit),
    .res_i           (res),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .operand_tag_o   (operand_tag_o),
    .decoded_value_o (decoded_value_o),
    .was_count_o     (was_count_o),
    .status_o        (status_o)
  );

endmodule
